>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define GSE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also runs during reset.
`define GSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/gse_pkg.sv
// ----------------------------------------------------------------------------
// gse_pkg
// Shared widths, codes and control structs of the GF(2) elimination unit.
// ----------------------------------------------------------------------------
package gse_pkg;

    localparam int WORD_W = 64;   // bits per row word
    localparam int BIT_W  = 6;    // bit index inside a word
    localparam int COL_W  = 7;    // column field width
    localparam int WIDX_W = 2;    // word index field width

    // row kind, taken from the opcode of the last term
    localparam logic OP_ELIM   = 1'b0;
    localparam logic OP_REDUCE = 1'b1;

    // commands from the sequencer to one word cell
    typedef struct packed {
        logic set_en;     // set bit i_bit
        logic xor_en;     // xor in the eliminator slice
        logic shift_en;   // take the upper neighbor's word
        logic clr;        // drop the word
    } t_cell_ctl;

    // status from one word cell
    typedef struct packed {
        logic             nz;     // word has a set bit
        logic [BIT_W-1:0] lead;   // highest set bit of the word
    } t_cell_stat;

endpackage

>>> rtl/gse_cell.sv
// ----------------------------------------------------------------------------
// gse_cell
// One 64-bit word of the row accumulator: sets terms, applies eliminator
// slices, reports its highest set bit and shifts toward word zero on output.
// ----------------------------------------------------------------------------
module gse_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  gse_pkg::t_cell_ctl         i_ctl,
    input  logic [gse_pkg::BIT_W-1:0]  i_bit,
    input  logic [gse_pkg::WORD_W-1:0] i_elim,
    input  logic [gse_pkg::WORD_W-1:0] i_up,
    output logic [gse_pkg::WORD_W-1:0] o_word,
    output gse_pkg::t_cell_stat        o_stat
);

    logic [gse_pkg::WORD_W-1:0] r_word;
    logic [gse_pkg::WORD_W-1:0] n_word;

    // binary search for the top bit: six halving steps
    function automatic logic [gse_pkg::BIT_W-1:0] f_lead(input logic [gse_pkg::WORD_W-1:0] v);
        logic [gse_pkg::WORD_W-1:0] x;
        logic [gse_pkg::WORD_W-1:0] hi;
        logic [gse_pkg::WORD_W-1:0] msk;
        logic [gse_pkg::BIT_W-1:0]  l;
        x = v;
        l = '0;
        for (int k = gse_pkg::BIT_W - 1; k >= 0; k--) begin
            msk = (64'd1 << (1 << k)) - 64'd1;
            hi  = (x >> (1 << k)) & msk;
            if (|hi) begin
                l[k] = 1'b1;
                x    = hi;
            end else begin
                x = x & msk;
            end
        end
        return l;
    endfunction

    always_comb begin
        n_word = r_word;
        priority if (i_ctl.clr) begin
            n_word = '0;
        end else if (i_ctl.shift_en) begin
            n_word = i_up;
        end else if (i_ctl.xor_en) begin
            n_word = r_word ^ i_elim;
        end else if (i_ctl.set_en) begin
            n_word = r_word | (64'd1 << i_bit);
        end else begin
            n_word = r_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else begin
            r_word <= n_word;
        end
    end

    assign o_word      = r_word;
    assign o_stat.nz   = |r_word;
    assign o_stat.lead = f_lead(r_word);

endmodule

>>> rtl/gf2_special_gauss_elimination_unit.sv
// ----------------------------------------------------------------------------
// gf2_special_gauss_elimination_unit
// GF(2) row reduction against a table of eliminator rows kept by lead column.
// ----------------------------------------------------------------------------
//  channel | valid       | ready       | fields
//  --------+-------------+-------------+--------------------------------------
//  terms   | i_in_valid  | o_in_ready  | i_opcode i_column i_row_end
//  words   | o_out_valid | i_out_ready | o_word_index o_row_word o_lead_column
//          |             |             | o_is_zero o_promoted o_last_word
//
//  A term that does not end a row sets its bit in the accumulator.
//  Eliminator row end: lead search, then read-or-merge write (a zero row is dropped).
//  Reduced row end: a lead search plus registered table read for each eliminator
//  applied, then ROW_WORDS output words, each loaded as the output register frees.
//  Terms are refused from row end until an eliminator row is merged or dropped, or
//  a reduced row's last word enters the output register; that register lets a new
//  row stream in while it waits. Reset clears the accumulator and the presence bits;
//  table rows need none.
module gf2_special_gauss_elimination_unit #(
    parameter int NUM_COLUMNS = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_opcode,
    input  logic [gse_pkg::COL_W-1:0]   i_column,
    input  logic                        i_row_end,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [gse_pkg::WIDX_W-1:0]  o_word_index,
    output logic [gse_pkg::WORD_W-1:0]  o_row_word,
    output logic [gse_pkg::COL_W-1:0]   o_lead_column,
    output logic                        o_is_zero,
    output logic                        o_promoted,
    output logic                        o_last_word
);

    localparam int ROW_WORDS = (NUM_COLUMNS + 63) / 64;
    localparam int ROW_W     = ROW_WORDS * gse_pkg::WORD_W;
    localparam int LW        = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEAD,
        S_XOR,
        S_MERGE,
        S_OUT
    } t_state;

    t_state                         r_state;
    logic                           r_op;
    logic                           r_pres;
    logic [LW-1:0]                  r_lead_idx;
    logic [gse_pkg::COL_W-1:0]      r_lead_col;
    logic                           r_zero;
    logic                           r_prom;
    logic [gse_pkg::WIDX_W-1:0]     r_wcnt;
    logic [NUM_COLUMNS-1:0]         r_present;
    logic                           r_out_valid;
    logic [gse_pkg::WIDX_W-1:0]     r_out_widx;
    logic [gse_pkg::WORD_W-1:0]     r_out_word;
    logic [gse_pkg::COL_W-1:0]      r_out_lead;
    logic                           r_out_zero;
    logic                           r_out_prom;
    logic                           r_out_last;

    logic [ROW_W-1:0]               r_mem [NUM_COLUMNS];
    logic [ROW_W-1:0]               r_rdata;

    gse_pkg::t_cell_ctl             cell_ctl  [ROW_WORDS];
    gse_pkg::t_cell_stat            cell_stat [ROW_WORDS];
    logic [gse_pkg::WORD_W-1:0]     cell_word [ROW_WORDS];
    logic [gse_pkg::WORD_W-1:0]     cell_up   [ROW_WORDS];

    logic [ROW_W-1:0]               acc;
    logic                           nz;
    logic [7:0]                     lead8;
    logic [LW-1:0]                  lead_idx;
    logic                           pres_now;
    logic                           in_acc;
    logic                           col_ok;
    logic                           out_load;
    logic                           mem_we;
    logic [LW-1:0]                  mem_waddr;
    logic [ROW_W-1:0]               mem_wdata;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign col_ok     = (int'(i_column) < NUM_COLUMNS);
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // row lead from the cells' per-word leads
    always_comb begin
        nz    = 1'b0;
        lead8 = '0;
        for (int w = 0; w < ROW_WORDS; w++) begin
            acc[w*gse_pkg::WORD_W +: gse_pkg::WORD_W] = cell_word[w];
            if (cell_stat[w].nz) begin
                nz    = 1'b1;
                lead8 = 8'((w << gse_pkg::BIT_W) + int'(cell_stat[w].lead));
            end
        end
    end

    assign lead_idx = lead8[LW-1:0];
    assign pres_now = r_present[lead_idx];

    always_comb begin
        for (int w = 0; w < ROW_WORDS; w++) begin
            cell_ctl[w].set_en   = in_acc && col_ok && (int'(i_column[gse_pkg::BIT_W]) == w);
            cell_ctl[w].xor_en   = (r_state == S_XOR);
            cell_ctl[w].shift_en = out_load;
            cell_ctl[w].clr      = (r_state == S_MERGE)
                                 || ((r_state == S_LEAD) && (r_op == gse_pkg::OP_ELIM) && !nz);
            cell_up[w]           = (w == ROW_WORDS - 1) ? '0 : cell_word[(w + 1) % ROW_WORDS];
        end
    end

    genvar g;
    generate
        for (g = 0; g < ROW_WORDS; g++) begin : g_cell
            gse_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (cell_ctl[g]),
                .i_bit   (i_column[gse_pkg::BIT_W-1:0]),
                .i_elim  (r_rdata[g*gse_pkg::WORD_W +: gse_pkg::WORD_W]),
                .i_up    (cell_up[g]),
                .o_word  (cell_word[g]),
                .o_stat  (cell_stat[g])
            );
        end
    endgenerate

    // table write: promotion of a reduced row, or merge of an eliminator row
    always_comb begin
        mem_we    = (r_state == S_MERGE)
                 || ((r_state == S_LEAD) && (r_op == gse_pkg::OP_REDUCE) && nz && !pres_now);
        mem_waddr = (r_state == S_MERGE) ? r_lead_idx : lead_idx;
        mem_wdata = (r_state == S_MERGE) ? (acc | (r_pres ? r_rdata : '0)) : acc;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[lead_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_present   <= '0;
            r_out_valid <= 1'b0;
            r_wcnt      <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_row_end) begin
                        r_op    <= i_opcode;
                        r_state <= S_LEAD;
                    end
                end
                S_LEAD: begin
                    if (r_op == gse_pkg::OP_ELIM) begin
                        r_pres     <= pres_now;
                        r_lead_idx <= lead_idx;
                        r_state    <= nz ? S_MERGE : S_IDLE;
                    end else if (!nz) begin
                        r_zero     <= 1'b1;
                        r_prom     <= 1'b0;
                        r_lead_col <= '0;
                        r_wcnt     <= '0;
                        r_state    <= S_OUT;
                    end else if (!pres_now) begin
                        r_present[lead_idx] <= 1'b1;
                        r_zero     <= 1'b0;
                        r_prom     <= 1'b1;
                        r_lead_col <= lead8[gse_pkg::COL_W-1:0];
                        r_wcnt     <= '0;
                        r_state    <= S_OUT;
                    end else begin
                        r_state <= S_XOR;
                    end
                end
                S_XOR: begin
                    r_state <= S_LEAD;
                end
                S_MERGE: begin
                    r_present[r_lead_idx] <= 1'b1;
                    r_state               <= S_IDLE;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_wcnt <= r_wcnt + 1'b1;
                        if (r_wcnt == gse_pkg::WIDX_W'(ROW_WORDS - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // output word register: load from word zero of the chain
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_widx  <= r_wcnt;
                r_out_word  <= cell_word[0];
                r_out_lead  <= r_lead_col;
                r_out_zero  <= r_zero;
                r_out_prom  <= r_prom;
                r_out_last  <= (r_wcnt == gse_pkg::WIDX_W'(ROW_WORDS - 1));
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_word_index  = r_out_widx;
    assign o_row_word    = r_out_word;
    assign o_lead_column = r_out_lead;
    assign o_is_zero     = r_out_zero;
    assign o_promoted    = r_out_prom;
    assign o_last_word   = r_out_last;

endmodule

>>> rtl/gse_checker.sv
// ----------------------------------------------------------------------------
// gse_checker
// Port-level checks of the GF(2) elimination unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gse_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        i_row_end,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [gse_pkg::WIDX_W-1:0]  o_word_index,
    input logic [gse_pkg::WORD_W-1:0]  o_row_word,
    input logic [gse_pkg::COL_W-1:0]   o_lead_column,
    input logic                        o_is_zero,
    input logic                        o_promoted,
    input logic                        o_last_word
);

    `GSE_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> o_out_valid, "output word dropped while stalled")
    `GSE_ASSERT(a_out_stable, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> ($stable(o_row_word) && $stable(o_word_index)), "stalled output word changed")
    `GSE_ASSERT(a_zero_row, i_clk, i_rst_n, (o_out_valid && o_is_zero) |-> ((o_lead_column == '0) && !o_promoted), "zero row with lead or promotion")
    `GSE_ASSERT(a_word_run, i_clk, i_rst_n, (o_out_valid && i_out_ready && !o_last_word) |=> (o_out_valid && (o_word_index == $past(o_word_index) + 2'd1)), "gap or skip in word run")
    `GSE_ASSERT(a_row_end_busy, i_clk, i_rst_n, (i_in_valid && o_in_ready && i_row_end) |=> !o_in_ready, "term taken right after row end")

endmodule

bind gf2_special_gauss_elimination_unit gse_checker u_gse_checker (.*);

>>> sim/gf2_special_gauss_elimination_unit_tb.sv
// ----------------------------------------------------------------------------
// gf2_special_gauss_elimination_unit_tb
// Drives term streams into the GF(2) elimination unit and checks every output
// word. The directed table covers the extreme columns, each row kind, a term
// set twice, an opcode that changes inside a row, a merge into a slot that is
// already taken, and a row that reduces to zero. Random rows follow and are
// checked against an in-bench model of the eliminator table. Both channels
// stall in random bursts. The receiver also holds off once for a long stretch,
// and the sender waits once for the pipe to drain.
// ----------------------------------------------------------------------------
module gf2_special_gauss_elimination_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCOL        = 128;
    localparam int ROW_WORDS   = (NCOL + gse_pkg::WORD_W - 1) / gse_pkg::WORD_W;
    localparam int ROW_BITS    = ROW_WORDS * gse_pkg::WORD_W;
    localparam int ITEMS       = 220;
    localparam int DIR_N       = 16;
    localparam int TAIL_ITEMS  = 30;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE      = 300;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic                       op;
        logic [gse_pkg::COL_W-1:0]  col;
        logic                       row_end;
        logic                       chk;      // expected words typed in below
        logic [gse_pkg::WORD_W-1:0] w0;
        logic [gse_pkg::WORD_W-1:0] w1;
        logic [gse_pkg::COL_W-1:0]  lead;
        logic                       zero;
        logic                       prom;
    } t_term;

    typedef struct packed {
        logic [gse_pkg::WIDX_W-1:0] widx;
        logic [gse_pkg::WORD_W-1:0] word;
        logic [gse_pkg::COL_W-1:0]  lead;
        logic                       zero;
        logic                       prom;
        logic                       last_w;
    } t_word;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic                         i_opcode;
    logic [gse_pkg::COL_W-1:0]    i_column;
    logic                         i_row_end;
    logic                         o_out_valid;
    logic                         i_out_ready;
    logic [gse_pkg::WIDX_W-1:0]   o_word_index;
    logic [gse_pkg::WORD_W-1:0]   o_row_word;
    logic [gse_pkg::COL_W-1:0]    o_lead_column;
    logic                         o_is_zero;
    logic                         o_promoted;
    logic                         o_last_word;

    gf2_special_gauss_elimination_unit #(
        .NUM_COLUMNS (NCOL)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_column      (i_column),
        .i_row_end     (i_row_end),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_word_index  (o_word_index),
        .o_row_word    (o_row_word),
        .o_lead_column (o_lead_column),
        .o_is_zero     (o_is_zero),
        .o_promoted    (o_promoted),
        .o_last_word   (o_last_word)
    );

    // op, column, row_end, typed, word0, word1, lead, zero, promoted
    t_term dir_table [DIR_N] = '{
        // lowest column into an empty table: promoted with lead 0
        '{gse_pkg::OP_REDUCE, 7'd0,   1'b1, 1'b1, 64'h1, 64'h0, 7'd0, 1'b0, 1'b1},
        // highest column
        '{gse_pkg::OP_REDUCE, 7'd127, 1'b1, 1'b1, 64'h0, 64'h8000_0000_0000_0000,
          7'd127, 1'b0, 1'b1},
        // same row again cancels against its own eliminator
        '{gse_pkg::OP_REDUCE, 7'd127, 1'b1, 1'b1, 64'h0, 64'h0, 7'd0, 1'b1, 1'b0},
        // eliminator {64,70,100}: repeated term, reduce opcode before the end
        '{gse_pkg::OP_ELIM,   7'd64,  1'b0, 1'b0, 64'h0, 64'h0, 7'd0, 1'b0, 1'b0},
        '{gse_pkg::OP_ELIM,   7'd64,  1'b0, 1'b0, 64'h0, 64'h0, 7'd0, 1'b0, 1'b0},
        '{gse_pkg::OP_REDUCE, 7'd70,  1'b0, 1'b0, 64'h0, 64'h0, 7'd0, 1'b0, 1'b0},
        '{gse_pkg::OP_ELIM,   7'd100, 1'b1, 1'b0, 64'h0, 64'h0, 7'd0, 1'b0, 1'b0},
        // eliminator opcode dropped by the reduce end: {64,100} -> {70}
        '{gse_pkg::OP_ELIM,   7'd100, 1'b0, 1'b0, 64'h0, 64'h0, 7'd0, 1'b0, 1'b0},
        '{gse_pkg::OP_REDUCE, 7'd64,  1'b1, 1'b0, 64'h0, 64'h0, 7'd0, 1'b0, 1'b0},
        // merge {3,127} into the occupied slot 127
        '{gse_pkg::OP_ELIM,   7'd3,   1'b0, 1'b0, 64'h0, 64'h0, 7'd0, 1'b0, 1'b0},
        '{gse_pkg::OP_ELIM,   7'd127, 1'b1, 1'b0, 64'h0, 64'h0, 7'd0, 1'b0, 1'b0},
        '{gse_pkg::OP_REDUCE, 7'd127, 1'b1, 1'b0, 64'h0, 64'h0, 7'd0, 1'b0, 1'b0},
        // two-step chain down to zero
        '{gse_pkg::OP_REDUCE, 7'd0,   1'b0, 1'b0, 64'h0, 64'h0, 7'd0, 1'b0, 1'b0},
        '{gse_pkg::OP_REDUCE, 7'd3,   1'b1, 1'b0, 64'h0, 64'h0, 7'd0, 1'b0, 1'b0},
        // word boundary
        '{gse_pkg::OP_REDUCE, 7'd63,  1'b1, 1'b0, 64'h0, 64'h0, 7'd0, 1'b0, 1'b0},
        '{gse_pkg::OP_REDUCE, 7'd64,  1'b1, 1'b0, 64'h0, 64'h0, 7'd0, 1'b0, 1'b0}
    };

    t_term stim [$];
    t_word expected_words [$];

    logic [ROW_BITS-1:0] elim_rows [NCOL];
    logic [NCOL-1:0]     elim_here;
    logic [ROW_BITS-1:0] pending_row;

    int   fail_count     = 0;
    int   words_seen     = 0;
    int   taken          = 0;
    int   cycles         = 0;
    logic long_hold_done = 1'b0;
    logic quiet_tail     = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        elim_here   = '0;
        pending_row = '0;
        foreach (elim_rows[c]) elim_rows[c] = '0;
    end

    function automatic int lead_of(logic [ROW_BITS-1:0] r);
        int c;
        c = -1;
        for (int k = 0; k < NCOL; k++)
            if (r[k]) c = k;
        return c;
    endfunction

    // Update the table model with one accepted term and queue a reduced row's words.
    task automatic take_term(input t_term t);
        int    lead;
        int    n;
        logic  prom;
        t_word w;
        if (t.col < NCOL) pending_row[t.col] = 1'b1;
        if (!t.row_end) return;
        lead = lead_of(pending_row);
        if (t.op == gse_pkg::OP_ELIM) begin
            if (lead >= 0) begin
                elim_rows[lead] |= pending_row;
                elim_here[lead] = 1'b1;
            end
        end else begin
            prom = 1'b0;
            n    = 0;
            while (lead >= 0 && n <= NCOL && !prom) begin
                if (!elim_here[lead]) begin
                    elim_rows[lead] = pending_row;
                    elim_here[lead] = 1'b1;
                    prom = 1'b1;
                end else begin
                    pending_row ^= elim_rows[lead];
                    lead = lead_of(pending_row);
                end
                n++;
            end
            for (int k = 0; k < ROW_WORDS; k++) begin
                w.widx   = gse_pkg::WIDX_W'(k);
                w.word   = pending_row[k*gse_pkg::WORD_W +: gse_pkg::WORD_W];
                w.lead   = (lead >= 0) ? gse_pkg::COL_W'(lead) : '0;
                w.zero   = (lead < 0);
                w.prom   = prom;
                w.last_w = (k == ROW_WORDS - 1);
                if (t.chk) begin
                    w.word = (k == 0) ? t.w0 : t.w1;
                    w.lead = t.lead;
                    w.zero = t.zero;
                    w.prom = t.prom;
                end
                expected_words.push_back(w);
            end
        end
        pending_row = '0;
    endtask

    task automatic check_field(input string name, input logic [gse_pkg::WORD_W-1:0] exp_v,
                               input logic [gse_pkg::WORD_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    task automatic check_word();
        t_word e;
        if (expected_words.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual idx %0d data %h",
                     $time, o_word_index, o_row_word);
            fail_count++;
            return;
        end
        e = expected_words.pop_front();
        check_field("word_index",  gse_pkg::WORD_W'(e.widx),   gse_pkg::WORD_W'(o_word_index));
        check_field("row_word",    e.word,                     o_row_word);
        check_field("lead_column", gse_pkg::WORD_W'(e.lead),   gse_pkg::WORD_W'(o_lead_column));
        check_field("is_zero",     gse_pkg::WORD_W'(e.zero),   gse_pkg::WORD_W'(o_is_zero));
        check_field("promoted",    gse_pkg::WORD_W'(e.prom),   gse_pkg::WORD_W'(o_promoted));
        check_field("last_word",   gse_pkg::WORD_W'(e.last_w), gse_pkg::WORD_W'(o_last_word));
    endtask

    // Check outputs before the predictor runs so a word never meets its own row.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && i_out_ready) begin
                check_word();
                words_seen++;
            end
            if (i_in_valid && o_in_ready === 1'b1) begin
                take_term(stim[taken]);
                taken++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Output side: random stalls, calm stretches, and one long hold-off.
    initial begin
        int pick;
        int gap;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && words_seen >= 24) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                long_hold_done = 1'b1;
            end else if (quiet_tail) begin
                i_out_ready <= 1'b1;
            end else begin
                pick = $urandom_range(0, 15);
                if (pick < 3) begin
                    gap = $urandom_range(1, 10);
                    i_out_ready <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end else if (pick == 3) begin
                    i_out_ready <= 1'b1;
                    repeat ($urandom_range(20, 60) - 1) @(negedge i_clk);
                end else begin
                    i_out_ready <= 1'b1;
                end
            end
        end
    end

    // Input side: build the term list, then stream it.
    initial begin
        t_term t;
        int    len;
        int    gap;
        int    pause_at;
        int    tail_at;
        logic  kind;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_opcode   = 1'b0;
        i_column   = '0;
        i_row_end  = 1'b0;

        foreach (dir_table[d]) stim.push_back(dir_table[d]);
        while (stim.size() < ITEMS) begin
            len  = $urandom_range(1, 8);
            kind = ($urandom_range(0, 99) < 35) ? gse_pkg::OP_ELIM : gse_pkg::OP_REDUCE;
            for (int j = 0; j < len; j++) begin
                t         = '0;
                t.op      = (j == len - 1) ? kind : 1'($urandom_range(0, 1));
                // crowd half the terms into the two ends to build long chains
                if ($urandom_range(0, 1))
                    t.col = gse_pkg::COL_W'($urandom_range(0, NCOL - 1));
                else if ($urandom_range(0, 1))
                    t.col = gse_pkg::COL_W'($urandom_range(0, 15));
                else
                    t.col = gse_pkg::COL_W'($urandom_range(NCOL - 16, NCOL - 1));
                t.row_end = (j == len - 1);
                stim.push_back(t);
            end
        end
        pause_at = stim.size() / 2;
        tail_at  = stim.size() - TAIL_ITEMS;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < stim.size(); k++) begin
            if (k >= tail_at) begin
                quiet_tail = 1'b1;
            end else if (k == pause_at) begin
                if (expected_words.size() != 0) begin
                    i_in_valid <= 1'b0;
                    while (expected_words.size() != 0) @(negedge i_clk);
                end
            end else if ($urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 10);
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_opcode   <= stim[k].op;
            i_column   <= stim[k].col;
            i_row_end  <= stim[k].row_end;
            do @(posedge i_clk); while (o_in_ready !== 1'b1);
            @(negedge i_clk);
        end
        i_in_valid <= 1'b0;

        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/gse_pkg.sv
rtl/gse_cell.sv
rtl/gf2_special_gauss_elimination_unit.sv
rtl/gse_checker.sv
sim/gf2_special_gauss_elimination_unit_tb.sv
